/* design/rau_pkg.sv */
// rau_pkg: shared types, codes and widths for the rational arithmetic unit.
// Used by every module of the unit; depends on nothing.
package rau_pkg;

   // operand and result part width (fixed by the port fields)
   localparam int DW = 32;
   localparam int PW = 2 * DW;

   // default for the overflow limit parameter
   localparam int RAU_WIDTH = 32;

   // command codes
   localparam logic [2:0] CMD_ADD = 3'd0;
   localparam logic [2:0] CMD_SUB = 3'd1;
   localparam logic [2:0] CMD_MUL = 3'd2;
   localparam logic [2:0] CMD_DIV = 3'd3;
   localparam logic [2:0] CMD_CMP = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OVF  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;
   localparam logic [1:0] ST_ZDEN = 2'd3;

   // datapath micro-operations issued by the sequencer
   typedef enum logic [4:0] {
      U_NONE,
      U_LOAD,
      U_GCD_DEN,   // gcd(ad, bd) -> g1
      U_DIV_DA,    // ad / g1 -> u0
      U_DIV_DB,    // bd / g1 -> u1
      U_MUL_T1,    // an * u1 -> prod_a
      U_MUL_T2,    // bn * u0 -> prod_b
      U_MUL_DEN,   // ad * u1 -> den
      U_ADDSUB,    // signed sum of prod_a, prod_b -> prod_a
      U_GCD_X,     // gcd(an, t) -> g1
      U_GCD_Y,     // gcd(ad, q) -> g2
      U_DIV_X0,    // an / g1 -> u0
      U_DIV_X1,    // q / g2 -> u1
      U_DIV_X2,    // ad / g2 -> u2
      U_DIV_X3,    // t / g1 -> u3
      U_MUL_NUM,   // u0 * u1 -> prod_a
      U_MUL_DEN2,  // u2 * u3 -> den
      U_CHECK,     // overflow check on prod_a, den
      U_MUL_CL,    // an * bd -> prod_a
      U_MUL_CR,    // bn * ad -> den
      U_CMP,       // compare prod_a against den
      U_GCD_RED,   // gcd(num, den) -> g1
      U_DIV_RN,    // num / g1 -> rn
      U_DIV_RD     // den / g1 -> rd
   } uop_type;

   // sequencer to datapath
   typedef struct packed {
      logic    load;
      logic    start;
      logic    finish;
      uop_type uop;
   } dp_ctrl_type;

   // datapath to sequencer
   typedef struct packed {
      logic       unit_done;
      logic       err;
      logic       zero_op;
      logic       num_zero;
      logic [2:0] cmd;
   } dp_status_type;

   // micro-ops that run on the multi-cycle gcd or divide unit
   function automatic logic uop_is_long(input uop_type u);
      logic r;
      case (u)
         U_GCD_DEN, U_GCD_X, U_GCD_Y, U_GCD_RED,
         U_DIV_DA, U_DIV_DB, U_DIV_X0, U_DIV_X1, U_DIV_X2, U_DIV_X3,
         U_DIV_RN, U_DIV_RD: r = 1'b1;
         default:            r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

/* design/rau_gcd.sv */
// rau_gcd: binary gcd of two nonzero operands, one shift or subtract per cycle.
// Depends on rau_pkg for the operand width.
module rau_gcd
   import rau_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] op_a,
   input  logic [DW-1:0] op_b,
   output logic          done,
   output logic [DW-1:0] result
);

   localparam int KW = $clog2(DW);

   logic [DW-1:0] x_ff, y_ff, result_ff;
   logic [KW-1:0] k_ff;
   logic          run_ff, done_ff;

   // one binary gcd step per cycle; common factors of two counted in k
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            x_ff   <= op_a;
            y_ff   <= op_b;
            k_ff   <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            if (x_ff == y_ff) begin
               result_ff <= x_ff << k_ff;
               run_ff    <= 1'b0;
               done_ff   <= 1'b1;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_ff <= x_ff >> 1;
               y_ff <= y_ff >> 1;
               k_ff <= k_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_ff <= x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_ff <= y_ff >> 1;
            end else if (x_ff > y_ff) begin
               x_ff <= (x_ff - y_ff) >> 1;
            end else begin
               y_ff <= (y_ff - x_ff) >> 1;
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

/* design/rau_div.sv */
// rau_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on rau_pkg for the operand width.
module rau_div
   import rau_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] rem_ff, quo_ff, dsr_ff;
   logic [CW-1:0] cnt_ff;
   logic          run_ff, done_ff;
   logic [DW:0]   shifted;
   logic [DW+1:0] trial;

   // shift in the next dividend bit and try the subtract
   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff <= '0;
            quo_ff <= dividend;
            dsr_ff <= divisor;
            cnt_ff <= CW'(DW);
            run_ff <= 1'b1;
         end else if (run_ff) begin
            rem_ff <= trial[DW+1] ? shifted[DW-1:0] : trial[DW-1:0];
            quo_ff <= {quo_ff[DW-2:0], !trial[DW+1]};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* design/rau_datapath.sv */
// rau_datapath: operand and work registers, multiplier, adder, compare and
// result registers; holds the gcd and divide units. Depends on rau_pkg,
// rau_gcd and rau_div.
module rau_datapath
   import rau_pkg::*;
#(
   parameter int WIDTH = RAU_WIDTH
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_ctrl_type   ctrl,
   output dp_status_type sts,
   input  logic [2:0]    req_cmd,
   input  logic          req_a_negative,
   input  logic [DW-1:0] req_a_numer,
   input  logic [DW-1:0] req_a_denom,
   input  logic          req_b_negative,
   input  logic [DW-1:0] req_b_numer,
   input  logic [DW-1:0] req_b_denom,
   output logic          rsp_r_negative,
   output logic [DW-1:0] rsp_r_numer,
   output logic [DW-1:0] rsp_r_denom,
   output logic [1:0]    rsp_status,
   output logic          rsp_a_greater,
   output logic          rsp_a_equal
);

   // result parts may hold at most this many bits
   localparam int LIM_BITS = (WIDTH > DW) ? DW : WIDTH;

   logic [2:0]    cmd_ff;
   logic          aneg_ff, bneg_ff;
   logic [DW-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic [DW-1:0] g1_ff, g2_ff, u0_ff, u1_ff, u2_ff, u3_ff, rn_ff, rd_ff;
   logic [PW-1:0] prod_a_ff, prod_b_ff, den_ff;
   logic          carry_ff, rneg_ff, gt_ff, eq_ff;
   logic [1:0]    status_ff;

   logic          out_neg_ff, out_gt_ff, out_eq_ff;
   logic [DW-1:0] out_numer_ff, out_denom_ff;
   logic [1:0]    out_status_ff;

   logic [DW-1:0] q_w, t_w;
   logic [DW-1:0] gcd_a, gcd_b, gcd_res, div_n, div_d, div_q;
   logic          gcd_start, div_start, gcd_done, div_done;
   logic [DW-1:0] mul_a, mul_b;
   logic [PW-1:0] mul_p;
   logic          b_eff;
   logic [PW:0]   sum_w;
   logic [PW-1:0] d12_w, d21_w;
   logic          ovf_w, cmp_gt, cmp_eq, out_zero;
   logic          zden_w, div0_w;

   // cross-cancel operands: multiply pairs (an,bd),(ad,bn); divide (an,bn),(ad,bd)
   assign q_w = (cmd_ff == CMD_MUL) ? bn_ff : bd_ff;
   assign t_w = (cmd_ff == CMD_MUL) ? bd_ff : bn_ff;

   // gcd operand select
   always_comb begin
      case (ctrl.uop)
         U_GCD_X:   begin gcd_a = an_ff;  gcd_b = t_w;  end
         U_GCD_Y:   begin gcd_a = ad_ff;  gcd_b = q_w;  end
         U_GCD_RED: begin gcd_a = prod_a_ff[DW-1:0]; gcd_b = den_ff[DW-1:0]; end
         default:   begin gcd_a = ad_ff;  gcd_b = bd_ff; end
      endcase
   end

   // divider operand select
   always_comb begin
      case (ctrl.uop)
         U_DIV_DB: begin div_n = bd_ff; div_d = g1_ff; end
         U_DIV_X0: begin div_n = an_ff; div_d = g1_ff; end
         U_DIV_X1: begin div_n = q_w;   div_d = g2_ff; end
         U_DIV_X2: begin div_n = ad_ff; div_d = g2_ff; end
         U_DIV_X3: begin div_n = t_w;   div_d = g1_ff; end
         U_DIV_RN: begin div_n = prod_a_ff[DW-1:0]; div_d = g1_ff; end
         U_DIV_RD: begin div_n = den_ff[DW-1:0];    div_d = g1_ff; end
         default:  begin div_n = ad_ff; div_d = g1_ff; end
      endcase
   end

   // multiplier operand select
   always_comb begin
      case (ctrl.uop)
         U_MUL_T1:   begin mul_a = an_ff; mul_b = u1_ff; end
         U_MUL_T2:   begin mul_a = bn_ff; mul_b = u0_ff; end
         U_MUL_DEN:  begin mul_a = ad_ff; mul_b = u1_ff; end
         U_MUL_NUM:  begin mul_a = u0_ff; mul_b = u1_ff; end
         U_MUL_DEN2: begin mul_a = u2_ff; mul_b = u3_ff; end
         U_MUL_CL:   begin mul_a = an_ff; mul_b = bd_ff; end
         U_MUL_CR:   begin mul_a = bn_ff; mul_b = ad_ff; end
         default:    begin mul_a = an_ff; mul_b = bd_ff; end
      endcase
   end

   assign mul_p = PW'(mul_a) * PW'(mul_b);

   assign gcd_start = ctrl.start && (ctrl.uop == U_GCD_DEN || ctrl.uop == U_GCD_X ||
                                     ctrl.uop == U_GCD_Y || ctrl.uop == U_GCD_RED);
   assign div_start = ctrl.start && uop_is_long(ctrl.uop) && !gcd_start;

   rau_gcd u_gcd (
      .clock  (clock),
      .reset  (reset),
      .start  (gcd_start),
      .op_a   (gcd_a),
      .op_b   (gcd_b),
      .done   (gcd_done),
      .result (gcd_res)
   );

   rau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   // signed add of the two cross products; subtract flips b's sign
   assign b_eff = (cmd_ff == CMD_SUB) ? (!bneg_ff && bn_ff != '0) : bneg_ff;
   assign sum_w = {1'b0, prod_a_ff} + {1'b0, prod_b_ff};
   assign d12_w = prod_a_ff - prod_b_ff;
   assign d21_w = prod_b_ff - prod_a_ff;

   // overflow past the result limit
   assign ovf_w = carry_ff || ((prod_a_ff >> LIM_BITS) != '0) || ((den_ff >> LIM_BITS) != '0);

   // compare a = prod_a/(..) against b with cross products prod_a and den
   always_comb begin
      cmp_gt = 1'b0;
      cmp_eq = 1'b0;
      if (aneg_ff != bneg_ff) begin
         if (prod_a_ff == '0 && den_ff == '0) cmp_eq = 1'b1;
         else                                cmp_gt = bneg_ff;
      end else if (prod_a_ff == den_ff) begin
         cmp_eq = 1'b1;
      end else if (aneg_ff) begin
         cmp_gt = prod_a_ff < den_ff;
      end else begin
         cmp_gt = prod_a_ff > den_ff;
      end
   end

   // input classification at load
   assign zden_w = (req_a_denom == '0) || (req_b_denom == '0);
   assign div0_w = (req_cmd == CMD_DIV) && (req_b_numer == '0);

   // work registers
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff    <= req_cmd;
         an_ff     <= req_a_numer;
         ad_ff     <= req_a_denom;
         bn_ff     <= req_b_numer;
         bd_ff     <= req_b_denom;
         aneg_ff   <= req_a_negative && (req_a_numer != '0);
         bneg_ff   <= req_b_negative && (req_b_numer != '0);
         status_ff <= zden_w ? ST_ZDEN : (div0_w ? ST_DIV0 : ST_OK);
         rn_ff     <= '0;
         rd_ff     <= DW'(1);
         carry_ff  <= 1'b0;
         rneg_ff   <= 1'b0;
         gt_ff     <= 1'b0;
         eq_ff     <= 1'b0;
      end
      if (gcd_done) begin
         if (ctrl.uop == U_GCD_Y) g2_ff <= gcd_res;
         else                     g1_ff <= gcd_res;
      end
      if (div_done) begin
         case (ctrl.uop)
            U_DIV_DA, U_DIV_X0: u0_ff <= div_q;
            U_DIV_DB, U_DIV_X1: u1_ff <= div_q;
            U_DIV_X2:           u2_ff <= div_q;
            U_DIV_X3:           u3_ff <= div_q;
            U_DIV_RN:           rn_ff <= div_q;
            U_DIV_RD:           rd_ff <= div_q;
            default:            ;
         endcase
      end
      if (ctrl.start) begin
         case (ctrl.uop)
            U_MUL_T1, U_MUL_CL: prod_a_ff <= mul_p;
            U_MUL_T2:           prod_b_ff <= mul_p;
            U_MUL_DEN, U_MUL_DEN2, U_MUL_CR: den_ff <= mul_p;
            U_MUL_NUM: begin
               prod_a_ff <= mul_p;
               rneg_ff   <= aneg_ff ^ bneg_ff;
            end
            U_ADDSUB: begin
               if (aneg_ff == b_eff) begin
                  prod_a_ff <= sum_w[PW-1:0];
                  carry_ff  <= sum_w[PW];
                  rneg_ff   <= aneg_ff;
               end else if (prod_a_ff >= prod_b_ff) begin
                  prod_a_ff <= d12_w;
                  rneg_ff   <= aneg_ff;
               end else begin
                  prod_a_ff <= d21_w;
                  rneg_ff   <= b_eff;
               end
            end
            U_CHECK: begin
               if (ovf_w) status_ff <= ST_OVF;
            end
            U_CMP: begin
               gt_ff <= cmp_gt;
               eq_ff <= cmp_eq;
            end
            default: ;
         endcase
      end
   end

   // result register: errors, compares and zero results read as +0/1
   assign out_zero = (status_ff != ST_OK) || (rn_ff == '0);

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         out_neg_ff    <= out_zero ? 1'b0 : rneg_ff;
         out_numer_ff  <= out_zero ? '0 : rn_ff;
         out_denom_ff  <= out_zero ? DW'(1) : rd_ff;
         out_status_ff <= status_ff;
         out_gt_ff     <= gt_ff;
         out_eq_ff     <= eq_ff;
      end
   end

   assign rsp_r_negative = out_neg_ff;
   assign rsp_r_numer    = out_numer_ff;
   assign rsp_r_denom    = out_denom_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_a_greater  = out_gt_ff;
   assign rsp_a_equal    = out_eq_ff;

   // status to the sequencer
   assign sts.unit_done = gcd_done || div_done;
   assign sts.err       = status_ff != ST_OK;
   assign sts.zero_op   = ((cmd_ff == CMD_MUL) && (an_ff == '0 || bn_ff == '0)) ||
                          ((cmd_ff == CMD_DIV) && (an_ff == '0));
   assign sts.num_zero  = prod_a_ff == '0;
   assign sts.cmd       = cmd_ff;

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(gcd_done && div_done))
      else $error("gcd and divider finished together");

endmodule

/* design/rau_ctrl.sv */
// rau_ctrl: sequencer that walks the micro-op chain for each command and
// runs the input and result handshakes. Depends on rau_pkg.
module rau_ctrl
   import rau_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output dp_ctrl_type   ctrl,
   input  dp_status_type sts
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_NEXT,
      S_ISSUE,
      S_WAIT,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   uop_type   uop_ff, uop_in, nxt;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // next micro-op; U_NONE ends the item
   always_comb begin
      case (uop_ff)
         U_LOAD: begin
            if (sts.err) begin
               nxt = U_NONE;
            end else begin
               case (sts.cmd)
                  CMD_ADD, CMD_SUB: nxt = U_GCD_DEN;
                  CMD_MUL, CMD_DIV: nxt = sts.zero_op ? U_NONE : U_GCD_X;
                  CMD_CMP:          nxt = U_MUL_CL;
                  default:          nxt = U_NONE;
               endcase
            end
         end
         U_GCD_DEN:  nxt = U_DIV_DA;
         U_DIV_DA:   nxt = U_DIV_DB;
         U_DIV_DB:   nxt = U_MUL_T1;
         U_MUL_T1:   nxt = U_MUL_T2;
         U_MUL_T2:   nxt = U_MUL_DEN;
         U_MUL_DEN:  nxt = U_ADDSUB;
         U_ADDSUB:   nxt = U_CHECK;
         U_GCD_X:    nxt = U_GCD_Y;
         U_GCD_Y:    nxt = U_DIV_X0;
         U_DIV_X0:   nxt = U_DIV_X1;
         U_DIV_X1:   nxt = U_DIV_X2;
         U_DIV_X2:   nxt = U_DIV_X3;
         U_DIV_X3:   nxt = U_MUL_NUM;
         U_MUL_NUM:  nxt = U_MUL_DEN2;
         U_MUL_DEN2: nxt = U_CHECK;
         U_CHECK:    nxt = (sts.err || sts.num_zero) ? U_NONE : U_GCD_RED;
         U_MUL_CL:   nxt = U_MUL_CR;
         U_MUL_CR:   nxt = U_CMP;
         U_GCD_RED:  nxt = U_DIV_RN;
         U_DIV_RN:   nxt = U_DIV_RD;
         default:    nxt = U_NONE;
      endcase
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // commands to the datapath
   assign ctrl.load   = (state_ff == S_IDLE) && req_valid;
   assign ctrl.start  = state_ff == S_ISSUE;
   assign ctrl.finish = (state_ff == S_FINISH) && slot_free;
   assign ctrl.uop    = uop_ff;

   always_comb begin
      state_in     = state_ff;
      uop_in       = uop_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               uop_in   = U_LOAD;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (nxt == U_NONE) begin
               state_in = S_FINISH;
            end else begin
               uop_in   = nxt;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE:  state_in = uop_is_long(uop_ff) ? S_WAIT : S_NEXT;
         S_WAIT:   if (sts.unit_done) state_in = S_NEXT;
         S_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         uop_ff       <= U_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         uop_ff       <= uop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      sts.unit_done |-> state_ff == S_WAIT)
      else $error("unit finished outside a wait");

   a_wait_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT && !sts.unit_done) |=> state_ff == S_WAIT)
      else $error("left wait before unit finished");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FINISH)
      else $error("result raised outside finish");

endmodule

/* design/rational_arithmetic_unit_core.sv */
// rational_arithmetic_unit_core: top level of the rational arithmetic unit.
// Depends on rau_pkg, rau_ctrl and rau_datapath.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  cmd, a and b sign, numerator, denominator
//   rsp      out        rsp_valid / rsp_stall  sign, numerator, denominator, status, flags
//
// One item at a time. Input errors and zero multiply/divide operands skip the micro-op
// chain, and compare uses only the multiplier and comparator; add/subtract and
// multiply/divide are paced by the one-step binary gcd unit and the restoring divider,
// each used several times per item.
// Synchronous reset clears the sequencer and the result valid; no clearing pass.
// A finished result waits in the output register while the next item is taken.
module rational_arithmetic_unit_core
   import rau_pkg::*;
#(
   parameter int WIDTH = RAU_WIDTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [2:0]    req_cmd,
   input  logic          req_a_negative,
   input  logic [DW-1:0] req_a_numer,
   input  logic [DW-1:0] req_a_denom,
   input  logic          req_b_negative,
   input  logic [DW-1:0] req_b_numer,
   input  logic [DW-1:0] req_b_denom,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic          rsp_r_negative,
   output logic [DW-1:0] rsp_r_numer,
   output logic [DW-1:0] rsp_r_denom,
   output logic [1:0]    rsp_status,
   output logic          rsp_a_greater,
   output logic          rsp_a_equal
);

   dp_ctrl_type   ctrl;
   dp_status_type sts;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl),
      .sts       (sts)
   );

   rau_datapath #(
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .sts            (sts),
      .req_cmd        (req_cmd),
      .req_a_negative (req_a_negative),
      .req_a_numer    (req_a_numer),
      .req_a_denom    (req_a_denom),
      .req_b_negative (req_b_negative),
      .req_b_numer    (req_b_numer),
      .req_b_denom    (req_b_denom),
      .rsp_r_negative (rsp_r_negative),
      .rsp_r_numer    (rsp_r_numer),
      .rsp_r_denom    (rsp_r_denom),
      .rsp_status     (rsp_status),
      .rsp_a_greater  (rsp_a_greater),
      .rsp_a_equal    (rsp_a_equal)
   );

endmodule

/* bench/tb.sv */
// tb: self-checking bench for rational_arithmetic_unit_core.
// Drives random and directed rational operations, predicts each result
// in-bench and checks every returned item; depends on rau_pkg and the RTL.

class rau_scoreboard;
   typedef struct packed {
      logic        neg;
      logic [31:0] numer;
      logic [31:0] denom;
      logic [1:0]  status;
      logic        gt;
      logic        eq;
   } rat_result_type;

   rat_result_type pending[$];
   int unsigned errors;

   static function longint unsigned gcd_u64(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // exact rational arithmetic with 64-bit intermediates
   static function rat_result_type predict(logic [2:0] cmd, logic a_s, logic [31:0] a_n,
                                           logic [31:0] a_d, logic b_s, logic [31:0] b_n,
                                           logic [31:0] b_d, int unsigned width);
      rat_result_type r;
      longint unsigned an, ad, bn, bd, lim, g, g2, da, db, t1, t2, den, num;
      logic aneg, bneg, beff, ovf;
      int unsigned bits;
      an = a_n; ad = a_d; bn = b_n; bd = b_d;
      aneg = a_s && an != 0;
      bneg = b_s && bn != 0;
      bits = (width > 32) ? 32 : width;
      lim = (64'd1 << bits) - 1;
      r = '{neg: 1'b0, numer: '0, denom: 32'd1, status: rau_pkg::ST_OK, gt: 1'b0, eq: 1'b0};
      if (ad == 0 || bd == 0) begin
         r.status = rau_pkg::ST_ZDEN;
      end else if (cmd == rau_pkg::CMD_ADD || cmd == rau_pkg::CMD_SUB) begin
         g = gcd_u64(ad, bd);
         da = ad / g; db = bd / g;
         t1 = an * db; t2 = bn * da; den = ad * db;
         beff = (cmd == rau_pkg::CMD_SUB) ? (!bneg && bn != 0) : bneg;
         ovf = 1'b0;
         if (aneg == beff) begin
            num = t1 + t2;
            if (num < t1) ovf = 1'b1;
            r.neg = aneg;
         end else if (t1 >= t2) begin
            num = t1 - t2;
            r.neg = aneg;
         end else begin
            num = t2 - t1;
            r.neg = beff;
         end
         if (ovf || num > lim || den > lim) begin
            r.status = rau_pkg::ST_OVF;
            r.neg = 1'b0;
         end else begin
            g = gcd_u64(num, den);
            r.numer = 32'(num / g);
            r.denom = 32'(den / g);
         end
      end else if (cmd == rau_pkg::CMD_MUL || cmd == rau_pkg::CMD_DIV) begin
         if (cmd == rau_pkg::CMD_DIV && bn == 0) begin
            r.status = rau_pkg::ST_DIV0;
         end else if (an != 0 && bn != 0) begin
            if (cmd == rau_pkg::CMD_MUL) begin
               g = gcd_u64(an, bd); g2 = gcd_u64(ad, bn);
               num = (an / g) * (bn / g2);
               den = (ad / g2) * (bd / g);
            end else begin
               g = gcd_u64(an, bn); g2 = gcd_u64(ad, bd);
               num = (an / g) * (bd / g2);
               den = (ad / g2) * (bn / g);
            end
            if (num > lim || den > lim) begin
               r.status = rau_pkg::ST_OVF;
            end else begin
               g = gcd_u64(num, den);
               r.numer = 32'(num / g);
               r.denom = 32'(den / g);
               r.neg = aneg != bneg;
            end
         end
      end else if (cmd == rau_pkg::CMD_CMP) begin
         t1 = an * bd; t2 = bn * ad;
         if (aneg != bneg) begin
            if (t1 == 0 && t2 == 0) r.eq = 1'b1;
            else r.gt = bneg;
         end else if (t1 == t2) r.eq = 1'b1;
         else if (aneg) r.gt = t1 < t2;
         else r.gt = t1 > t2;
      end
      if (r.numer == 0) begin
         r.neg = 1'b0;
         r.denom = 32'd1;
      end
      return r;
   endfunction

   function void note_request(logic [2:0] cmd, logic a_s, logic [31:0] a_n, logic [31:0] a_d,
                              logic b_s, logic [31:0] b_n, logic [31:0] b_d);
      pending = {pending, predict(cmd, a_s, a_n, a_d, b_s, b_n, b_d, rau_pkg::RAU_WIDTH)};
   endfunction

   function void check_result(rat_result_type got);
      rat_result_type want;
      if (pending.size() == 0) begin
         $error("unexpected result item");
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got.neg !== want.neg) begin
         $error("r_negative: expected %0d, got %0d", want.neg, got.neg); errors++;
      end
      if (got.numer !== want.numer) begin
         $error("r_numer: expected %0d, got %0d", want.numer, got.numer); errors++;
      end
      if (got.denom !== want.denom) begin
         $error("r_denom: expected %0d, got %0d", want.denom, got.denom); errors++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status); errors++;
      end
      if (got.gt !== want.gt) begin
         $error("a_greater: expected %0d, got %0d", want.gt, got.gt); errors++;
      end
      if (got.eq !== want.eq) begin
         $error("a_equal: expected %0d, got %0d", want.eq, got.eq); errors++;
      end
   endfunction
endclass

module tb;
   import rau_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_CYCLES = 20000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [2:0]    req_cmd = '0;
   logic          req_a_negative = 1'b0;
   logic [DW-1:0] req_a_numer = '0;
   logic [DW-1:0] req_a_denom = '0;
   logic          req_b_negative = 1'b0;
   logic [DW-1:0] req_b_numer = '0;
   logic [DW-1:0] req_b_denom = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic          rsp_r_negative;
   logic [DW-1:0] rsp_r_numer;
   logic [DW-1:0] rsp_r_denom;
   logic [1:0]    rsp_status;
   logic          rsp_a_greater;
   logic          rsp_a_equal;

   rau_scoreboard scoreboard = new();
   int unsigned   send_idle_pct = 0;
   int unsigned   stall_pct = 0;
   int unsigned   idle_count = 0;

   rational_arithmetic_unit_core dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // receiver: random stall, check accepted results
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         scoreboard.check_result({rsp_r_negative, rsp_r_numer, rsp_r_denom, rsp_status,
                                  rsp_a_greater, rsp_a_equal});
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // present one item, hold it until accepted; valid drops only while idling
   task automatic send_op(logic [2:0] cmd, logic a_s, logic [31:0] a_n, logic [31:0] a_d,
                          logic b_s, logic [31:0] b_n, logic [31:0] b_d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_a_negative <= a_s; req_a_numer <= a_n; req_a_denom <= a_d;
      req_b_negative <= b_s; req_b_numer <= b_n; req_b_denom <= b_d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      scoreboard.note_request(cmd, a_s, a_n, a_d, b_s, b_n, b_d);
   endtask

   // operand value with mostly small magnitudes so results stay in range
   function automatic logic [31:0] rand_part();
      int unsigned k;
      k = $urandom_range(9);
      if (k < 4) return $urandom_range(20);
      if (k < 7) return $urandom_range(4000);
      if (k < 8) return $urandom_range(70000);
      return $urandom;
   endfunction

   task automatic send_random();
      logic [2:0] cmd;
      logic [31:0] ad, bd;
      cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      ad = rand_part();
      bd = rand_part();
      if (ad == 0 && $urandom_range(9) != 0) ad = 1;
      if (bd == 0 && $urandom_range(9) != 0) bd = 1;
      send_op(cmd, 1'($urandom_range(1)), rand_part(), ad, 1'($urandom_range(1)),
              rand_part(), bd);
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain();
      req_valid <= 1'b0;
      while (scoreboard.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: each command, extremes, zero and error cases
      send_op(CMD_ADD, 1'b0, 32'd1, 32'd2, 1'b0, 32'd1, 32'd3);
      send_op(CMD_SUB, 1'b0, 32'd1, 32'd2, 1'b0, 32'd1, 32'd2);
      send_op(CMD_SUB, 1'b1, 32'd3, 32'd4, 1'b0, 32'd5, 32'd6);
      send_op(CMD_MUL, 1'b1, 32'd6, 32'd35, 1'b0, 32'd14, 32'd15);
      send_op(CMD_DIV, 1'b0, 32'd7, 32'd9, 1'b1, 32'd14, 32'd3);
      send_op(CMD_CMP, 1'b0, 32'd1, 32'd3, 1'b0, 32'd2, 32'd6);
      send_op(CMD_CMP, 1'b1, 32'd0, 32'd5, 1'b0, 32'd0, 32'd7);
      send_op(CMD_CMP, 1'b1, 32'd1, 32'd3, 1'b1, 32'd1, 32'd2);
      send_op(CMD_CMP, 1'b0, 32'd1, 32'd3, 1'b1, 32'd1, 32'd2);
      send_op(CMD_ADD, 1'b0, 32'd1, 32'd0, 1'b0, 32'd1, 32'd1);
      send_op(CMD_DIV, 1'b0, 32'd1, 32'd1, 1'b0, 32'd1, 32'd0);
      send_op(CMD_DIV, 1'b0, 32'd5, 32'd1, 1'b1, 32'd0, 32'd3);
      send_op(CMD_MUL, 1'b1, 32'd0, 32'd9, 1'b1, 32'd4, 32'd9);
      send_op(CMD_ADD, 1'b0, 32'hFFFFFFFF, 32'd1, 1'b0, 32'd1, 32'd1);
      send_op(CMD_SUB, 1'b1, 32'hFFFFFFFF, 32'd1, 1'b0, 32'hFFFFFFFF, 32'd1);
      send_op(CMD_ADD, 1'b0, 32'd1, 32'hFFFFFFFF, 1'b0, 32'd1, 32'hFFFFFFFE);
      send_op(CMD_MUL, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 32'd1);
      send_op(CMD_MUL, 1'b0, 32'h10000, 32'd1, 1'b0, 32'h10000, 32'd1);
      send_op(CMD_DIV, 1'b1, 32'hFFFFFFFF, 32'h80000000, 1'b1, 32'h7FFFFFFF, 32'h3);
      send_op(CMD_CMP, 1'b1, 32'hFFFFFFFF, 32'd1, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_op(3'd5, 1'b1, 32'd3, 32'd4, 1'b0, 32'd1, 32'd2);
      send_op(3'd7, 1'b0, 32'd3, 32'd0, 1'b0, 32'd1, 32'd2);
      drain();

      // random phases under different idle and stall mixes
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1: begin send_idle_pct = 75; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 75; end
            3: begin send_idle_pct = 34; stall_pct = 34; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         repeat (245) send_random();
         if (phase == 2) drain();
      end

      drain();
      stall_pct = 0;
      repeat (50) @(posedge clock);
      if (scoreboard.errors == 0 && scoreboard.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

/* rational_arithmetic_unit_core.f */
design/rau_pkg.sv
design/rau_gcd.sv
design/rau_div.sv
design/rau_datapath.sv
design/rau_ctrl.sv
design/rational_arithmetic_unit_core.sv
bench/tb.sv
